[rtl/sha1c_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1c_pkg
// Shared types, constants and round functions of the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1c_pkg;

	typedef enum logic [1:0] {
		OP_RESTART = 2'd0,
		OP_BYTE    = 2'd1,
		OP_FINISH  = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        failed;
		logic        last_word;
	} result_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
	} cmd_t;

	// head of the command queue as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_head_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_COMP,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_EMIT,
		ST_ERR
	} bstate_t;

	typedef logic [4:0][31:0]  chain_t;
	typedef logic [15:0][31:0] block_t;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LEN_START  = 6'd56;
	localparam logic [5:0] LAST_BYTE  = 6'd63;
	localparam logic [2:0] LAST_INDEX = 3'd4;
	localparam logic [6:0] ADD_ROUND  = 7'd80;

	function automatic logic [31:0] round_k(input logic [6:0] r);
		logic [31:0] k;
		if (r < 7'd20) begin
			k = 32'h5A827999;
		end else if (r < 7'd40) begin
			k = 32'h6ED9EBA1;
		end else if (r < 7'd60) begin
			k = 32'h8F1BBCDC;
		end else begin
			k = 32'hCA62C1D6;
		end
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (r < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (r >= 7'd40 && r < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage

[rtl/sha1c_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1c_core
// SHA-1 compression: one round per cycle over a 16-word schedule window,
// then a final step folds the working words into the chaining words.
// ----------------------------------------------------------------------------
module sha1c_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              init,
	input  logic              start,
	input  sha1c_pkg::block_t block,
	output logic              busy,
	output sha1c_pkg::chain_t chain
);

	sha1c_pkg::chain_t chain_q;
	logic              busy_q;
	logic [6:0]        round_q;
	logic [31:0]       a_q, b_q, c_q, d_q, e_q;
	logic [31:0]       w_q [16];
	logic [31:0]       t;
	logic [31:0]       w_new;
	logic [31:0]       x;

	always_comb begin
		t = {a_q[26:0], a_q[31:27]} + sha1c_pkg::round_f(round_q, b_q, c_q, d_q) + e_q
			+ w_q[0] + sha1c_pkg::round_k(round_q);
		x = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {x[30:0], x[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= '0;
			chain_q <= sha1c_pkg::H_INIT;
		end else if (init) begin
			chain_q <= sha1c_pkg::H_INIT;
		end else if (start) begin
			busy_q  <= 1'b1;
			round_q <= '0;
		end else if (busy_q) begin
			if (round_q == sha1c_pkg::ADD_ROUND) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
				busy_q     <= 1'b0;
			end else begin
				round_q <= round_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= block[i];
			end
		end else if (busy_q && round_q != sha1c_pkg::ADD_ROUND) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
	end

	assign busy  = busy_q;
	assign chain = chain_q;

endmodule

[rtl/sha1c_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1c_back
// Back end: block buffer, length and marks, padding sequencer and digest
// output; drives the compression core.
// ----------------------------------------------------------------------------
module sha1c_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1c_pkg::cmd_head_t  cmd_in,
	output logic                  cmd_take,
	output sha1c_pkg::result_t    res,
	output logic                  res_push,
	input  logic                  res_full
);

	sha1c_pkg::bstate_t state_q, state_d;
	sha1c_pkg::bstate_t ret_q, ret_d;
	logic [5:0]         cursor_q;
	logic [63:0]        bit_length_q;
	logic               error_q;
	logic               done_q;
	logic [2:0]         idx_q;
	logic [31:0]        block_q [16];
	sha1c_pkg::block_t  block_flat;

	logic               wr_en;
	logic [7:0]         wr_data;
	logic               len_add;
	logic               set_error;
	logic               restart;
	logic               set_done;
	logic               idx_clr;
	logic               core_start;
	logic               core_busy;
	sha1c_pkg::chain_t  chain;
	logic [64:0]        len_sum;
	logic [7:0]         len_byte;
	logic               stalled;

	assign stalled  = done_q | error_q;
	assign len_sum  = {1'b0, bit_length_q} + 65'd8;
	assign len_byte = bit_length_q[{~cursor_q[2:0], 3'b000} +: 8];

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			block_flat[i] = block_q[i];
		end
	end

	sha1c_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.init   (restart),
		.start  (core_start),
		.block  (block_flat),
		.busy   (core_busy),
		.chain  (chain)
	);

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			sha1c_pkg::ST_IDLE: begin
				if (cmd_in.valid) begin
					unique case (cmd_in.cmd.op)
						sha1c_pkg::OP_BYTE: begin
							if (!stalled && cursor_q == sha1c_pkg::LAST_BYTE) begin
								state_d = sha1c_pkg::ST_START;
								ret_d   = sha1c_pkg::ST_IDLE;
							end
						end
						sha1c_pkg::OP_FINISH: begin
							if (error_q) begin
								state_d = sha1c_pkg::ST_ERR;
							end else if (done_q) begin
								state_d = sha1c_pkg::ST_EMIT;
							end else if (cursor_q == sha1c_pkg::LAST_BYTE) begin
								state_d = sha1c_pkg::ST_START;
								ret_d   = sha1c_pkg::ST_PAD_ZERO;
							end else begin
								state_d = sha1c_pkg::ST_PAD_ZERO;
							end
						end
						default: begin
						end
					endcase
				end
			end
			sha1c_pkg::ST_START: begin
				state_d = sha1c_pkg::ST_COMP;
			end
			sha1c_pkg::ST_COMP: begin
				if (!core_busy) begin
					state_d = ret_q;
				end
			end
			sha1c_pkg::ST_PAD_ZERO: begin
				if (cursor_q == sha1c_pkg::LEN_START) begin
					state_d = sha1c_pkg::ST_PAD_LEN;
				end else if (cursor_q == sha1c_pkg::LAST_BYTE) begin
					state_d = sha1c_pkg::ST_START;
					ret_d   = sha1c_pkg::ST_PAD_ZERO;
				end
			end
			sha1c_pkg::ST_PAD_LEN: begin
				if (cursor_q == sha1c_pkg::LAST_BYTE) begin
					state_d = sha1c_pkg::ST_START;
					ret_d   = sha1c_pkg::ST_EMIT;
				end
			end
			sha1c_pkg::ST_EMIT: begin
				if (!res_full && idx_q == sha1c_pkg::LAST_INDEX) begin
					state_d = sha1c_pkg::ST_IDLE;
				end
			end
			sha1c_pkg::ST_ERR: begin
				if (!res_full) begin
					state_d = sha1c_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha1c_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs and datapath strobes
	always_comb begin
		cmd_take   = 1'b0;
		wr_en      = 1'b0;
		wr_data    = '0;
		len_add    = 1'b0;
		set_error  = 1'b0;
		restart    = 1'b0;
		set_done   = 1'b0;
		idx_clr    = 1'b0;
		core_start = 1'b0;
		res_push   = 1'b0;
		res        = '0;
		unique case (state_q)
			sha1c_pkg::ST_IDLE: begin
				idx_clr  = 1'b1;
				cmd_take = cmd_in.valid;
				if (cmd_in.valid) begin
					unique case (cmd_in.cmd.op)
						sha1c_pkg::OP_RESTART: begin
							restart = 1'b1;
						end
						sha1c_pkg::OP_BYTE: begin
							if (stalled) begin
								set_error = 1'b1;
							end else begin
								wr_en   = 1'b1;
								wr_data = cmd_in.cmd.data_byte;
								len_add = 1'b1;
							end
						end
						sha1c_pkg::OP_FINISH: begin
							if (!stalled) begin
								wr_en   = 1'b1;
								wr_data = sha1c_pkg::PAD_MARK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			sha1c_pkg::ST_START: begin
				core_start = 1'b1;
			end
			sha1c_pkg::ST_PAD_ZERO: begin
				wr_en = (cursor_q != sha1c_pkg::LEN_START);
			end
			sha1c_pkg::ST_PAD_LEN: begin
				wr_en    = 1'b1;
				wr_data  = len_byte;
				set_done = (cursor_q == sha1c_pkg::LAST_BYTE);
			end
			sha1c_pkg::ST_EMIT: begin
				res_push        = !res_full;
				res.digest_word = chain[idx_q];
				res.word_index  = idx_q;
				res.last_word   = (idx_q == sha1c_pkg::LAST_INDEX);
			end
			sha1c_pkg::ST_ERR: begin
				res_push      = !res_full;
				res.failed    = 1'b1;
				res.last_word = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sha1c_pkg::ST_IDLE;
			ret_q        <= sha1c_pkg::ST_IDLE;
			cursor_q     <= '0;
			bit_length_q <= '0;
			error_q      <= 1'b0;
			done_q       <= 1'b0;
			idx_q        <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (restart) begin
				cursor_q     <= '0;
				bit_length_q <= '0;
				error_q      <= 1'b0;
				done_q       <= 1'b0;
			end else begin
				if (wr_en) begin
					cursor_q <= cursor_q + 6'd1;
				end
				if (len_add) begin
					bit_length_q <= len_sum[63:0];
				end
				// byte while stalled, or length wrapped to zero
				if (set_error || (len_add && len_sum[64])) begin
					error_q <= 1'b1;
				end
				if (set_done) begin
					done_q <= 1'b1;
				end
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (res_push) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// big-endian byte lanes within each word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			block_q[cursor_q[5:2]][{~cursor_q[1:0], 3'b000} +: 8] <= wr_data;
		end
	end

endmodule

[rtl/sha1c_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1c_front
// Front end: accepts input items, decodes the opcode and queues commands
// for the back end; unused opcodes are accepted and dropped.
// ----------------------------------------------------------------------------
module sha1c_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  sha1c_pkg::item_t     item,
	output sha1c_pkg::cmd_head_t cmd_out,
	input  logic                 take
);

	sha1c_pkg::cmd_t                  slots_q [sha1c_pkg::QDepth];
	logic [sha1c_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [sha1c_pkg::QCntW-1:0]      count_q;
	logic                             op_ok;
	logic                             enq;
	logic                             deq;
	sha1c_pkg::cmd_t                  cmd;

	always_comb begin
		cmd.op        = sha1c_pkg::op_t'(item.opcode);
		cmd.data_byte = item.data_byte;
		unique case (item.opcode)
			sha1c_pkg::OP_RESTART,
			sha1c_pkg::OP_BYTE,
			sha1c_pkg::OP_FINISH: op_ok = 1'b1;
			default:              op_ok = 1'b0;
		endcase
	end

	assign full          = (count_q == sha1c_pkg::QCntW'(sha1c_pkg::QDepth));
	assign enq           = push && !full && op_ok;
	assign deq           = take && (count_q != '0);
	assign cmd_out.valid = (count_q != '0);
	assign cmd_out.cmd   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (deq && !enq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			slots_q[wr_ptr_q] <= cmd;
		end
	end

endmodule

[rtl/sha1c_result_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1c_result_queue
// Result queue between the back end and the result port.
// ----------------------------------------------------------------------------
module sha1c_result_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  sha1c_pkg::result_t wr_data,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output sha1c_pkg::result_t result
);

	sha1c_pkg::result_t             slots_q [sha1c_pkg::QDepth];
	logic [sha1c_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [sha1c_pkg::QCntW-1:0]    count_q;
	logic                           enq;
	logic                           deq;

	assign full   = (count_q == sha1c_pkg::QCntW'(sha1c_pkg::QDepth));
	assign empty  = (count_q == '0);
	assign enq    = wr && !full;
	assign deq    = pop && !empty;
	assign result = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (deq && !enq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[rtl/sha1_byte_stream_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 over a byte stream: restart, append byte, finish and read digest.
// ----------------------------------------------------------------------------
// Input channel: an item is taken when push is high and full is low. Items go
// into a four-entry command queue; the back end drains it one command at a
// time, so full rises only while the back end is busy.
// Result channel: while empty is low the oldest result sits on result; it
// leaves when pop is high. A finish gives five digest words (H0 first, the
// last flagged by last_word) or one failed result if the error mark is set.
// The 64th byte of a block starts the compression core (one round per cycle,
// then the final add), and the back end waits for it before the next command.
// A finish pads one byte per cycle from the cursor up to the end of the block,
// with one or two compressions, then emits five words at one per cycle while
// the result queue is not full; a repeat finish skips the padding and emits
// the stored digest.
// A stalled result side fills the four-entry result queue and then holds the
// back end; the input queue keeps taking items until it is full.
// Reset loads the initial chaining words, clears length, cursor, marks and
// both queues; the block buffer holds no defined contents until written.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  sha1c_pkg::item_t   item,
	output logic               empty,
	input  logic               pop,
	output sha1c_pkg::result_t result
);

	sha1c_pkg::cmd_head_t cmd_head;
	logic                 cmd_take;
	sha1c_pkg::result_t   res;
	logic                 res_push;
	logic                 res_full;

	sha1c_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.cmd_out (cmd_head),
		.take    (cmd_take)
	);

	sha1c_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_in   (cmd_head),
		.cmd_take (cmd_take),
		.res      (res),
		.res_push (res_push),
		.res_full (res_full)
	);

	sha1c_result_queue u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_push),
		.wr_data (res),
		.full    (res_full),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

[tb/tb_sha1_byte_stream_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_byte_stream_hasher
// Self-checking bench for the SHA-1 byte stream hasher. A short table of
// directed commands (empty message, "abc", repeat finish, error paths) and a
// long receiver hold precede random messages of restart, bytes and finish,
// sent under several idle and stall patterns. Every digest word is checked
// against an in-bench SHA-1 predictor or known digests in the table.
// ----------------------------------------------------------------------------
module tb_sha1_byte_stream_hasher;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         NUM_DIR     = 23;
	localparam int         PHASE_ITEMS = 107;
	localparam int         HOLD_CYCLES = 600;
	localparam int         TAIL_CYCLES = 300;
	localparam int         LIMIT_NS    = 20_000_000;

	// digests of the empty message and of "abc", word 0 in the low bits
	localparam sha1c_pkg::chain_t EMPTY_SHA1 = {32'hAFD80709, 32'h95601890,
		32'h3255BFEF, 32'h5E6B4B0D, 32'hDA39A3EE};
	localparam sha1c_pkg::chain_t ABC_SHA1 = {32'h9CD0D89D, 32'h7850C26C,
		32'hBA3E2571, 32'h4706816A, 32'hA9993E36};

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_DIGEST,
		CHK_FAILED
	} chk_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [7:0]        data_byte;
		chk_t              chk;
		sha1c_pkg::chain_t golden;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	sha1c_pkg::item_t   item;
	logic               empty;
	logic               pop;
	sha1c_pkg::result_t result;

	sha1_byte_stream_hasher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #6 clk = ~clk;

	// predictor state
	sha1c_pkg::chain_t  hash_st;
	logic [63:0]        bitlen_st;
	logic [7:0]         blk_st [64];
	int unsigned        cursor_st;
	bit                 err_st;
	bit                 done_st;
	sha1c_pkg::result_t step_out [5];

	sha1c_pkg::result_t digest_q [$];
	sha1c_pkg::result_t want;
	row_t               dir_rows [NUM_DIR];

	int idle_pct;
	int stall_pct;
	int hold_req;
	int hold_ack      = 0;
	int hold_left     = 0;
	int errors        = 0;
	int items_sent;
	int messages;
	int words_checked = 0;
	int failed_seen   = 0;
	int full_hits     = 0;

	function automatic void sha1_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++) begin
			w[i] = {blk_st[4*i], blk_st[4*i+1], blk_st[4*i+2], blk_st[4*i+3]};
		end
		for (int i = 16; i < 80; i++) begin
			t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {t[30:0], t[31]};
		end
		a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3]; e = hash_st[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = {a[26:0], a[31:27]} + f + e + w[i] + k;
			e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
		end
		hash_st[0] += a; hash_st[1] += b; hash_st[2] += c;
		hash_st[3] += d; hash_st[4] += e;
		cursor_st = 0;
	endfunction

	function automatic void restart_hash();
		hash_st   = sha1c_pkg::H_INIT;
		bitlen_st = '0;
		cursor_st = 0;
		err_st    = 1'b0;
		done_st   = 1'b0;
	endfunction

	// updates the predictor for one accepted command, returns the word count
	function automatic int predict_item(input sha1c_pkg::item_t it);
		int pos;
		case (it.opcode)
			sha1c_pkg::OP_RESTART: begin
				restart_hash();
				return 0;
			end
			sha1c_pkg::OP_BYTE: begin
				if (done_st || err_st) begin
					err_st = 1'b1;
				end else begin
					blk_st[cursor_st & 63] = it.data_byte;
					cursor_st = (cursor_st + 1) & 127;
					bitlen_st += 64'd8;
					if (bitlen_st == 64'd0) begin
						err_st = 1'b1;
					end
					if (cursor_st >= 64) begin
						sha1_compress();
					end
				end
				return 0;
			end
			sha1c_pkg::OP_FINISH: begin
				if (err_st) begin
					step_out[0] = '{digest_word: '0, word_index: '0, failed: 1'b1,
						last_word: 1'b1};
					return 1;
				end
				if (!done_st) begin
					pos = cursor_st & 63;
					blk_st[pos] = sha1c_pkg::PAD_MARK;
					pos++;
					if (pos > 56) begin
						while (pos < 64) begin
							blk_st[pos] = 8'h00;
							pos++;
						end
						sha1_compress();
						pos = 0;
					end
					while (pos < 56) begin
						blk_st[pos] = 8'h00;
						pos++;
					end
					for (int i = 0; i < 8; i++) begin
						blk_st[56+i] = bitlen_st[63-8*i -: 8];
					end
					sha1_compress();
					done_st = 1'b1;
				end
				for (int i = 0; i < 5; i++) begin
					step_out[i] = '{digest_word: hash_st[i], word_index: 3'(i), failed: 1'b0,
						last_word: (i == 4)};
				end
				return 5;
			end
			default: return 0;
		endcase
	endfunction

	task automatic send_item(input sha1c_pkg::item_t it, input chk_t chk = CHK_MODEL,
		input sha1c_pkg::chain_t golden = '0);
		int n;
		if ($urandom_range(0, 99) < idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		items_sent++;
		n = predict_item(it);
		case (chk)
			CHK_DIGEST: begin
				for (int i = 0; i < 5; i++) begin
					digest_q.push_back('{digest_word: golden[i], word_index: 3'(i),
						failed: 1'b0, last_word: (i == 4)});
				end
			end
			CHK_FAILED: begin
				digest_q.push_back('{digest_word: '0, word_index: '0, failed: 1'b1,
					last_word: 1'b1});
			end
			default: begin
				for (int i = 0; i < n; i++) begin
					digest_q.push_back(step_out[i]);
				end
			end
		endcase
	endtask

	task automatic send_op(input logic [1:0] opcode, input logic [7:0] data);
		sha1c_pkg::item_t it;
		it.opcode    = opcode;
		it.data_byte = data;
		send_item(it);
	endtask

	// sender holds off until every expected digest word has come back
	task automatic wait_drained();
		push <= 1'b0;
		do @(posedge clk); while (digest_q.size() != 0);
	endtask

	// one random message: mostly well formed, with some noise and broken tails
	task automatic send_message(input int budget);
		int len;
		len = 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: len = $urandom_range(0, 12);
			6, 7: begin
				case ($urandom_range(0, 8))
					0: len = 55;
					1: len = 56;
					2: len = 57;
					3: len = 63;
					4: len = 64;
					5: len = 65;
					6: len = 119;
					7: len = 120;
					default: len = 128;
				endcase
			end
			8: len = $urandom_range(13, 70);
			default: len = $urandom_range(70, 140);
		endcase
		// keep the phase near its item budget
		if (len > budget - 4) begin
			len = (budget > 4) ? budget - 4 : 0;
		end
		messages++;
		if ($urandom_range(0, 9) != 0) begin
			send_op(sha1c_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
		end
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 79))
				0: send_op(OP_UNUSED, 8'($urandom_range(0, 255)));
				1: send_op(sha1c_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
				default: ;
			endcase
			send_op(sha1c_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
		end
		send_op(sha1c_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
		case ($urandom_range(0, 9))
			0, 1: send_op(sha1c_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
			2: begin
				// stray bytes after finish set the error mark
				send_op(sha1c_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
				send_op(sha1c_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
	endtask

	// receiver: checks each transaction and drives pop
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (push && full) begin
				full_hits++;
			end
			if (pop && !empty) begin
				if (digest_q.size() == 0) begin
					$error("unexpected result: digest_word %h word_index %0d failed %0b",
						result.digest_word, result.word_index, result.failed);
					errors++;
				end else begin
					want = digest_q.pop_front();
					words_checked++;
					if (result.failed) begin
						failed_seen++;
					end
					if (result.digest_word !== want.digest_word) begin
						$error("digest_word: expected %h, got %h", want.digest_word,
							result.digest_word);
						errors++;
					end
					if (result.word_index !== want.word_index) begin
						$error("word_index: expected %0d, got %0d", want.word_index,
							result.word_index);
						errors++;
					end
					if (result.failed !== want.failed) begin
						$error("failed: expected %0b, got %0b", want.failed, result.failed);
						errors++;
					end
					if (result.last_word !== want.last_word) begin
						$error("last_word: expected %0b, got %0b", want.last_word,
							result.last_word);
						errors++;
					end
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack  = hold_req;
				hold_left = HOLD_CYCLES;
				pop <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		push       = 1'b0;
		item       = '0;
		idle_pct   = 0;
		stall_pct  = 0;
		hold_req   = 0;
		items_sent = 0;
		messages   = 0;
		for (int i = 0; i < 64; i++) begin
			blk_st[i] = 8'h00;
		end
		restart_hash();

		dir_rows = '{
			'{sha1c_pkg::OP_FINISH,  8'h00, CHK_DIGEST, EMPTY_SHA1},
			'{sha1c_pkg::OP_FINISH,  8'hFF, CHK_DIGEST, EMPTY_SHA1},
			'{sha1c_pkg::OP_BYTE,    8'h00, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_FINISH,  8'h00, CHK_FAILED, '0},
			'{OP_UNUSED,             8'hFF, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_FINISH,  8'h00, CHK_FAILED, '0},
			'{sha1c_pkg::OP_RESTART, 8'h00, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_BYTE,    8'h61, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_BYTE,    8'h62, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_BYTE,    8'h63, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_FINISH,  8'h00, CHK_DIGEST, ABC_SHA1},
			'{sha1c_pkg::OP_RESTART, 8'hFF, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_BYTE,    8'hFF, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_BYTE,    8'h00, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_RESTART, 8'h00, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_BYTE,    8'hFF, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_FINISH,  8'h00, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_FINISH,  8'h00, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_BYTE,    8'h5A, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_FINISH,  8'h00, CHK_FAILED, '0},
			'{sha1c_pkg::OP_RESTART, 8'h00, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_BYTE,    8'hA5, CHK_MODEL,  '0},
			'{sha1c_pkg::OP_FINISH,  8'h00, CHK_MODEL,  '0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIR; i++) begin
			send_item(sha1c_pkg::item_t'{opcode: dir_rows[i].opcode,
				data_byte: dir_rows[i].data_byte}, dir_rows[i].chk, dir_rows[i].golden);
		end
		wait_drained();

		// long receiver hold while commands keep coming: both queues fill up
		hold_req <= hold_req + 1;
		send_op(sha1c_pkg::OP_RESTART, 8'h00);
		send_op(sha1c_pkg::OP_BYTE, 8'h3C);
		for (int i = 0; i < 4; i++) begin
			send_op(sha1c_pkg::OP_FINISH, 8'h00);
		end
		send_op(sha1c_pkg::OP_RESTART, 8'h00);
		send_op(sha1c_pkg::OP_BYTE, 8'hC3);
		send_op(sha1c_pkg::OP_BYTE, 8'h0F);
		send_op(sha1c_pkg::OP_FINISH, 8'h00);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 52; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 52; end
				default: begin idle_pct = 19; stall_pct = 19; end
			endcase
			begin : phase_run
				int start_count;
				start_count = items_sent;
				while (items_sent - start_count < PHASE_ITEMS) begin
					send_message(PHASE_ITEMS - (items_sent - start_count));
				end
			end
			wait_drained();
		end

		idle_pct  = 0;
		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (digest_q.size() != 0) begin
			$error("%0d expected digest words never arrived", digest_q.size());
			errors++;
		end

		$display("run covered %0d commands (%0d random messages), %0d result words checked",
			items_sent, messages, words_checked);
		$display("error results seen: %0d, cycles with input held off: %0d", failed_seen,
			full_hits);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/sha1c_pkg.sv
rtl/sha1c_core.sv
rtl/sha1c_back.sv
rtl/sha1c_front.sv
rtl/sha1c_result_queue.sv
rtl/sha1_byte_stream_hasher.sv
tb/tb_sha1_byte_stream_hasher.sv
